FILE: hdl/qoa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package qoa_pkg;

  // CORDIC working precision (fraction bits of the x and y registers), 12 to 32.
  localparam int CW = 16;
  localparam int XW = CW + 3;
  localparam int ZW = 34;
  localparam int AW = 34;
  localparam int DW = 51;
  localparam int QW = 18;

  localparam logic [63:0] CORDIC_K64 = 64'd2608131496 >> (32 - CW);
  localparam logic signed [XW-1:0] CORDIC_K = XW'(CORDIC_K64);

  localparam int SH_DN = (CW > 14) ? CW - 14 : 0;
  localparam int SH_UP = (CW < 14) ? 14 - CW : 0;
  localparam logic signed [63:0] TQ_RND = (SH_DN > 0) ? (64'sd1 <<< (SH_DN - 1)) : 64'sd0;

  localparam logic signed [ZW-1:0] ATAN_TAB [32] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756, 34'sd42667331,
    34'sd21354465, 34'sd10679838, 34'sd5340245, 34'sd2670163, 34'sd1335087,
    34'sd667544, 34'sd333772, 34'sd166886, 34'sd83443, 34'sd41722, 34'sd20861,
    34'sd10430, 34'sd5215, 34'sd2608, 34'sd1304, 34'sd652, 34'sd326, 34'sd163,
    34'sd81, 34'sd41, 34'sd20, 34'sd10, 34'sd5, 34'sd3, 34'sd1, 34'sd1, 34'sd0
  };

  // Subtracted terms of the Hamilton product, indexed by output * 4 + term.
  localparam logic [15:0] QM_NEG = 16'h428E;

  localparam logic [2:0] OP_IDENT    = 3'd0;
  localparam logic [2:0] OP_ROT_X    = 3'd1;
  localparam logic [2:0] OP_ROT_Y    = 3'd2;
  localparam logic [2:0] OP_ROT_Z    = 3'd3;
  localparam logic [2:0] OP_ROT_AXIS = 3'd4;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [15:0] angle;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
  } qoa_in_t;

  typedef struct packed {
    logic signed [15:0] q_w;
    logic signed [15:0] q_x;
    logic signed [15:0] q_y;
    logic signed [15:0] q_z;
  } qoa_out_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_SET_ID,
    CMD_CORDIC,
    CMD_TRIG,
    CMD_BUILD_R,
    CMD_RV_W,
    CMD_MUL_RV,
    CMD_MUL_Q,
    CMD_MUL_SQ,
    CMD_SQRT_INIT,
    CMD_SQRT_STEP,
    CMD_LEN,
    CMD_DIV_INIT,
    CMD_DIV_STEP,
    CMD_DIV_DONE,
    CMD_NORM_Q,
    CMD_NORM_R,
    CMD_ROUND_Q,
    CMD_OUT
  } qoa_cmd_t;

  typedef struct packed {
    logic     load;
    qoa_cmd_t cmd;
    logic [4:0] idx;
  } qoa_ctl_t;

  typedef struct packed {
    logic [2:0] op;
  } qoa_sts_t;

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    if (v > 64'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -64'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] rnd14(input logic signed [AW-1:0] v);
    logic signed [63:0] t;
    t = 64'(v) + 64'sd8192;
    return sat16(t >>> 14);
  endfunction

  function automatic logic signed [15:0] to_q14(input logic signed [XW-1:0] v);
    logic signed [63:0] t;
    t = (64'(v) <<< SH_UP) + TQ_RND;
    return sat16(t >>> SH_DN);
  endfunction

endpackage
`default_nettype wire

FILE: hdl/qoa_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module qoa_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire qoa_pkg::qoa_in_t  in_data,
  input  wire qoa_pkg::qoa_ctl_t ctl,
  output qoa_pkg::qoa_sts_t      sts,
  output qoa_pkg::qoa_out_t      out_data
);
  import qoa_pkg::*;

  typedef enum logic [1:0] {ACC_Q, ACC_RV, ACC_SQ} acc_kind_t;
  typedef struct packed {
    logic      vld;
    acc_kind_t kind;
    logic [1:0] dst;
    logic      neg;
    logic      first;
    logic [1:0] part;
  } acc_t;

  logic signed [15:0]   q_r [4];
  logic signed [15:0]   r_r [4];
  logic signed [15:0]   n_r [4];
  logic signed [AW-1:0] v_r [4];
  logic signed [15:0]   ax_r [3];
  logic [2:0]           op_r;
  logic signed [XW-1:0] cx_r, cy_r;
  logic signed [ZW-1:0] cz_r;
  logic signed [15:0]   c_r, s_r;
  logic [63:0]          sum_r, sn_r, sr_r, sb_r;
  logic [32:0]          len_r;
  logic [DW-1:0]        rem_r, d_r;
  logic [QW-1:0]        quo_r;
  logic                 ovf_r, neg_r;
  logic signed [35:0]   prod_r;
  acc_t                 acc_r, acc_nxt;
  qoa_out_t             out_r;

  logic signed [17:0]   mul_a, mul_b;
  logic [1:0]           msel;
  logic signed [AW-1:0] vsel;
  logic [32:0]          mag;
  logic [DW-1:0]        num;
  logic signed [XW-1:0] dx, dy;
  logic [63:0]          trial;
  logic signed [AW-1:0] term;
  logic [63:0]          sq_term;
  logic [16:0]          sq_mag;
  logic signed [18:0]   sres;

  function automatic logic [32:0] abs33(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] a;
    a = (v < 0) ? -v : v;
    return a[32:0];
  endfunction

  assign sts.op = op_r;
  assign out_data = out_r;

  always_comb begin
    msel = (ctl.cmd == CMD_MUL_SQ) ? ctl.idx[3:2] : ctl.idx[1:0];
    vsel = v_r[msel];
    mag  = abs33(vsel);
    num  = (DW'(mag) << 14) + DW'(len_r >> 1);
    dx   = cy_r >>> ctl.idx;
    dy   = cx_r >>> ctl.idx;
    trial = sr_r + sb_r;
    sq_mag = (quo_r > QW'(65536) || ovf_r) ? 17'd65536 : quo_r[16:0];
    sres = neg_r ? -$signed({2'b00, sq_mag}) : $signed({2'b00, sq_mag});
    mul_a = '0;
    mul_b = '0;
    acc_nxt = '0;
    case (ctl.cmd)
      CMD_MUL_Q: begin
        mul_a = 18'(q_r[ctl.idx[1:0]]);
        mul_b = 18'(r_r[ctl.idx[3:2] ^ ctl.idx[1:0]]);
        acc_nxt.vld = 1'b1;
        acc_nxt.kind = ACC_Q;
        acc_nxt.dst = ctl.idx[3:2];
        acc_nxt.neg = QM_NEG[ctl.idx[3:0]];
        acc_nxt.first = (ctl.idx[1:0] == 2'd0);
      end
      CMD_MUL_RV: begin
        mul_a = 18'(ax_r[ctl.idx[1:0] - 2'd1]);
        mul_b = 18'(s_r);
        acc_nxt.vld = 1'b1;
        acc_nxt.kind = ACC_RV;
        acc_nxt.dst = ctl.idx[1:0];
      end
      CMD_MUL_SQ: begin
        mul_a = (ctl.idx[1:0] == 2'd2) ? $signed({1'b0, mag[32:16]})
                                       : $signed({2'b00, mag[15:0]});
        mul_b = (ctl.idx[1:0] == 2'd0) ? $signed({2'b00, mag[15:0]})
                                       : $signed({1'b0, mag[32:16]});
        acc_nxt.vld = (ctl.idx[1:0] != 2'd3);
        acc_nxt.kind = ACC_SQ;
        acc_nxt.first = (ctl.idx[3:0] == 4'd0);
        acc_nxt.part = ctl.idx[1:0];
      end
      default: begin
      end
    endcase
    term = AW'(prod_r);
    case (acc_r.part)
      2'd1:    sq_term = 64'($unsigned(prod_r)) << 17;
      2'd2:    sq_term = 64'($unsigned(prod_r)) << 32;
      default: sq_term = 64'($unsigned(prod_r));
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r[0] <= 16'sd16384;
      q_r[1] <= '0;
      q_r[2] <= '0;
      q_r[3] <= '0;
      acc_r  <= '0;
    end else begin
      acc_r <= acc_nxt;
      case (ctl.cmd)
        CMD_SET_ID: begin
          q_r[0] <= 16'sd16384;
          q_r[1] <= '0;
          q_r[2] <= '0;
          q_r[3] <= '0;
        end
        CMD_NORM_Q: begin
          for (int i = 0; i < 4; i++) q_r[i] <= n_r[i];
        end
        CMD_ROUND_Q: begin
          for (int i = 0; i < 4; i++) q_r[i] <= rnd14(v_r[i]);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (ctl.load) begin
      op_r  <= in_data.op;
      ax_r[0] <= in_data.axis_x;
      ax_r[1] <= in_data.axis_y;
      ax_r[2] <= in_data.axis_z;
      cx_r  <= CORDIC_K;
      cy_r  <= '0;
      cz_r  <= ZW'(in_data.angle) <<< 15;
    end
    if (acc_r.vld) begin
      case (acc_r.kind)
        ACC_Q: begin
          if (acc_r.first) begin
            v_r[acc_r.dst] <= acc_r.neg ? -term : term;
          end else begin
            v_r[acc_r.dst] <= acc_r.neg ? v_r[acc_r.dst] - term : v_r[acc_r.dst] + term;
          end
        end
        ACC_RV: v_r[acc_r.dst] <= term;
        default: sum_r <= acc_r.first ? sq_term : sum_r + sq_term;
      endcase
    end
    case (ctl.cmd)
      CMD_CORDIC: begin
        if (cz_r >= 0) begin
          cx_r <= cx_r - dx;
          cy_r <= cy_r + dy;
          cz_r <= cz_r - ATAN_TAB[ctl.idx];
        end else begin
          cx_r <= cx_r + dx;
          cy_r <= cy_r - dy;
          cz_r <= cz_r + ATAN_TAB[ctl.idx];
        end
      end
      CMD_TRIG: begin
        c_r <= to_q14(cx_r);
        s_r <= to_q14(cy_r);
      end
      CMD_BUILD_R: begin
        r_r[0] <= c_r;
        r_r[1] <= (op_r == OP_ROT_X) ? s_r : 16'sd0;
        r_r[2] <= (op_r == OP_ROT_Y) ? s_r : 16'sd0;
        r_r[3] <= (op_r == OP_ROT_Z) ? s_r : 16'sd0;
      end
      CMD_RV_W: v_r[0] <= AW'(c_r) <<< 14;
      CMD_SQRT_INIT: begin
        sn_r <= sum_r;
        sr_r <= '0;
        sb_r <= 64'd1 << 62;
      end
      CMD_SQRT_STEP: begin
        if (sn_r >= trial) begin
          sn_r <= sn_r - trial;
          sr_r <= (sr_r >> 1) + sb_r;
        end else begin
          sr_r <= sr_r >> 1;
        end
        sb_r <= sb_r >> 2;
      end
      CMD_LEN: len_r <= sr_r[32:0];
      CMD_DIV_INIT: begin
        rem_r <= num;
        d_r   <= DW'(len_r) << 17;
        ovf_r <= (num >= (DW'(len_r) << 18));
        neg_r <= (vsel < 0);
        quo_r <= '0;
      end
      CMD_DIV_STEP: begin
        if (rem_r >= d_r) begin
          rem_r <= rem_r - d_r;
          quo_r <= {quo_r[QW-2:0], 1'b1};
        end else begin
          quo_r <= {quo_r[QW-2:0], 1'b0};
        end
        d_r <= d_r >> 1;
      end
      CMD_DIV_DONE: begin
        if (len_r == '0) begin
          n_r[ctl.idx[1:0]] <= rnd14(vsel);
        end else begin
          n_r[ctl.idx[1:0]] <= sat16(64'(sres));
        end
      end
      CMD_NORM_R: begin
        for (int i = 0; i < 4; i++) r_r[i] <= n_r[i];
      end
      CMD_OUT: begin
        out_r.q_w <= q_r[0];
        out_r.q_x <= q_r[1];
        out_r.q_y <= q_r[2];
        out_r.q_z <= q_r[3];
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/qoa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module qoa_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire qoa_pkg::qoa_sts_t sts,
  output qoa_pkg::qoa_ctl_t      ctl
);
  import qoa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_CORDIC, S_TRIG, S_BUILD, S_RVW, S_RVM, S_RVD,
    S_SQ, S_SQD, S_SQRTI, S_SQRT, S_LEN, S_DIVI, S_DIV, S_DIVD, S_NEND,
    S_QM, S_QMD, S_ROUND, S_OUT
  } state_t;

  state_t     state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic [1:0] comp_r, comp_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       is_axis;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign is_axis   = (sts.op == OP_ROT_AXIS);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r + 5'd1;
    comp_nxt = comp_r;
    out_valid_nxt = out_valid_r && out_stall;
    ctl.load = 1'b0;
    ctl.cmd = CMD_NONE;
    ctl.idx = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        ctl.load = in_valid;
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        cnt_nxt = '0;
        if (sts.op == OP_IDENT) begin
          ctl.cmd = CMD_SET_ID;
          state_nxt = S_OUT;
        end else if (sts.op > OP_ROT_AXIS) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_CORDIC;
        end
      end
      S_CORDIC: begin
        ctl.cmd = CMD_CORDIC;
        if (cnt_r == 5'(CW - 1)) state_nxt = S_TRIG;
      end
      S_TRIG: begin
        ctl.cmd = CMD_TRIG;
        state_nxt = is_axis ? S_RVW : S_BUILD;
      end
      S_BUILD: begin
        ctl.cmd = CMD_BUILD_R;
        cnt_nxt = '0;
        state_nxt = S_QM;
      end
      S_RVW: begin
        ctl.cmd = CMD_RV_W;
        cnt_nxt = 5'd1;
        state_nxt = S_RVM;
      end
      S_RVM: begin
        ctl.cmd = CMD_MUL_RV;
        if (cnt_r == 5'd3) state_nxt = S_RVD;
      end
      S_RVD: begin
        cnt_nxt = '0;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        ctl.cmd = CMD_MUL_SQ;
        if (cnt_r == 5'd15) state_nxt = S_SQD;
      end
      S_SQD: state_nxt = S_SQRTI;
      S_SQRTI: begin
        ctl.cmd = CMD_SQRT_INIT;
        cnt_nxt = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        ctl.cmd = CMD_SQRT_STEP;
        if (cnt_r == 5'd31) state_nxt = S_LEN;
      end
      S_LEN: begin
        ctl.cmd = CMD_LEN;
        comp_nxt = '0;
        state_nxt = S_DIVI;
      end
      S_DIVI: begin
        ctl.cmd = CMD_DIV_INIT;
        ctl.idx = {3'd0, comp_r};
        cnt_nxt = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        ctl.cmd = CMD_DIV_STEP;
        if (cnt_r == 5'(QW - 1)) state_nxt = S_DIVD;
      end
      S_DIVD: begin
        ctl.cmd = CMD_DIV_DONE;
        ctl.idx = {3'd0, comp_r};
        comp_nxt = comp_r + 2'd1;
        state_nxt = (comp_r == 2'd3) ? S_NEND : S_DIVI;
      end
      S_NEND: begin
        cnt_nxt = '0;
        if (is_axis) begin
          ctl.cmd = CMD_NORM_R;
          state_nxt = S_QM;
        end else begin
          ctl.cmd = CMD_NORM_Q;
          state_nxt = S_OUT;
        end
      end
      S_QM: begin
        ctl.cmd = CMD_MUL_Q;
        if (cnt_r == 5'd15) state_nxt = S_QMD;
      end
      S_QMD: begin
        cnt_nxt = '0;
        state_nxt = is_axis ? S_ROUND : S_SQ;
      end
      S_ROUND: begin
        ctl.cmd = CMD_ROUND_Q;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          ctl.cmd = CMD_OUT;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      comp_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      comp_r <= comp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/quaternion_orientation_accumulator.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_stall   op, angle, axis_x, axis_y, axis_z
// out_     output     out_valid/out_stall q_w, q_x, q_y, q_z (new orientation)
//
// One transaction is processed at a time. Identity and unused codes skip the arithmetic
// and go straight to the output; rotations are sequenced through the 16-step CORDIC,
// the shared 18x18 multiplier, the 32-step square root and four 18-step divisions.
// rst_n is synchronous and active low; it restores the identity orientation.
// The finished result waits in an output register while out_stall is high.
module quaternion_orientation_accumulator (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire qoa_pkg::qoa_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output qoa_pkg::qoa_out_t     out_data
);
  import qoa_pkg::*;

  // The controller sequences each step; the datapath holds all arithmetic state.
  qoa_ctl_t ctl;
  qoa_sts_t sts;

  qoa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  qoa_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .ctl      (ctl),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

FILE: bench/tb_quaternion_orientation_accumulator.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_quaternion_orientation_accumulator;
  import qoa_pkg::*;

  // Arctangent steps of the CORDIC, in units where 2^32 is one full turn.
  localparam longint ArcTab [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0
  };
  localparam int Frac = CW;
  localparam int NumRandom = 930;

  int error_count = 0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // The scoreboard keeps its own copy of the orientation. Each accepted input
  // transaction advances that copy and queues the orientation it should return.
  class orientation_scoreboard;
    longint orient [4];
    qoa_out_t pending_q [$];
    int n_checked;

    function new();
      orient = '{16384, 0, 0, 0};
      n_checked = 0;
    endfunction

    function automatic longint clamp16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    // The >>> on a signed longint is a floor shift, as the block uses.
    function automatic longint round_q28(longint v);
      return clamp16((v + 8192) >>> 14);
    endfunction

    // Reduce a CORDIC register with Frac fraction bits to Q1.14, round half up.
    function automatic longint frac_to_q14(longint v);
      if (Frac > 14) return clamp16((v + (64'sd1 <<< (Frac - 15))) >>> (Frac - 14));
      if (Frac == 14) return clamp16(v);
      return clamp16(v <<< (14 - Frac));
    endfunction

    function automatic void half_angle_trig(longint half, output longint c,
                                            output longint s);
      longint x, y, z, dx, dy;
      x = longint'(64'd2608131496 >> (32 - Frac));
      y = 0;
      z = half;
      for (int i = 0; i < Frac; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= ArcTab[i];
        end else begin
          x += dx; y -= dy; z += ArcTab[i];
        end
      end
      c = frac_to_q14(x);
      s = frac_to_q14(y);
    endfunction

    function automatic void hamilton(input longint a[4], input longint b[4],
                                     output longint p[4]);
      p[0] = a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3];
      p[1] = a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2];
      p[2] = a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1];
      p[3] = a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0];
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned r, bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= r + bitv) begin
          n -= r + bitv;
          r = (r >> 1) + bitv;
        end else begin
          r >>= 1;
        end
        bitv >>= 2;
      end
      return r;
    endfunction

    // Scale to unit length; a zero length falls back to plain rounding.
    function automatic void unit_scale(input longint v[4], output longint o[4]);
      longint unsigned mag [4];
      longint unsigned total, len, qv;
      total = 0;
      for (int i = 0; i < 4; i++) begin
        mag[i] = v[i] < 0 ? 64'd0 - longint'(v[i]) : v[i];
        total += mag[i] * mag[i];
      end
      len = int_sqrt(total);
      for (int i = 0; i < 4; i++) begin
        if (len == 0) begin
          o[i] = round_q28(v[i]);
        end else begin
          qv = (mag[i] * 16384 + len / 2) / len;
          if (qv > 65536) qv = 65536;
          o[i] = clamp16(v[i] < 0 ? -longint'(qv) : longint'(qv));
        end
      end
    endfunction

    function void note_input(qoa_in_t t);
      longint c, s;
      longint r [4];
      longint rv [4];
      longint p [4];
      qoa_out_t e;
      if (t.op == OP_IDENT) begin
        orient = '{16384, 0, 0, 0};
      end else if (t.op inside {OP_ROT_X, OP_ROT_Y, OP_ROT_Z}) begin
        half_angle_trig(longint'(t.angle) * 32768, c, s);
        r = '{c, 0, 0, 0};
        r[t.op] = s;
        hamilton(orient, r, p);
        unit_scale(p, orient);
      end else if (t.op == OP_ROT_AXIS) begin
        half_angle_trig(longint'(t.angle) * 32768, c, s);
        rv[0] = c * 16384;
        rv[1] = longint'(t.axis_x) * s;
        rv[2] = longint'(t.axis_y) * s;
        rv[3] = longint'(t.axis_z) * s;
        unit_scale(rv, r);
        hamilton(orient, r, p);
        for (int i = 0; i < 4; i++) orient[i] = round_q28(p[i]);
      end
      e.q_w = orient[0][15:0];
      e.q_x = orient[1][15:0];
      e.q_y = orient[2][15:0];
      e.q_z = orient[3][15:0];
      pending_q.push_back(e);
    endfunction

    task check_result(qoa_out_t got);
      qoa_out_t e;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", got));
        return;
      end
      e = pending_q.pop_front();
      n_checked++;
      if (got.q_w !== e.q_w)
        report_mismatch($sformatf("q_w got %0d expected %0d", got.q_w, e.q_w));
      if (got.q_x !== e.q_x)
        report_mismatch($sformatf("q_x got %0d expected %0d", got.q_x, e.q_x));
      if (got.q_y !== e.q_y)
        report_mismatch($sformatf("q_y got %0d expected %0d", got.q_y, e.q_y));
      if (got.q_z !== e.q_z)
        report_mismatch($sformatf("q_z got %0d expected %0d", got.q_z, e.q_z));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  qoa_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  qoa_out_t out_data;

  orientation_scoreboard orient_sb = new();

  // Idle control: the percentage of idle cycles on each side, zero in the
  // calm stretch. A long hold-off on the receiver is requested by count.
  int idle_pct = 37;
  int hold_cycles = 0;
  bit stim_done = 1'b0;

  quaternion_orientation_accumulator i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Both channels are sampled at the rising edge; a transaction completes
  // where valid is high and stall is low.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) orient_sb.note_input(in_data);
    if (rst_n && out_valid && !out_stall) orient_sb.check_result(out_data);
  end

  // Receiver side. A hold-off request keeps stall high until its count runs out,
  // so the sender backs up against a full block.
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= ($urandom_range(99) < idle_pct);
      end
      @(posedge clk);
    end
  end

  // Offers one input transaction, holding it steady until it is taken. The
  // idle gap before it is random, so gaps land on every phase of the work.
  // Valid stays high after acceptance; the next call replaces the payload in
  // the same step, and stop_sending drops valid when the sender pauses.
  task automatic send_item(input qoa_in_t t);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic qoa_in_t rand_item();
    qoa_in_t t;
    int pick;
    pick = $urandom_range(99);
    if (pick < 4) t.op = OP_IDENT;
    else if (pick < 8) t.op = 3'($urandom_range(7, 5));
    else if (pick < 50) t.op = 3'($urandom_range(OP_ROT_Z, OP_ROT_X));
    else t.op = OP_ROT_AXIS;
    t.angle = 16'($urandom);
    // Mostly unit-length-ish axes with random content, some wild values.
    if ($urandom_range(3) == 0) begin
      t.axis_x = 16'($urandom);
      t.axis_y = 16'($urandom);
      t.axis_z = 16'($urandom);
    end else begin
      t.axis_x = 16'($signed($urandom_range(32768)) - 16384);
      t.axis_y = 16'($signed($urandom_range(32768)) - 16384);
      t.axis_z = 16'($signed($urandom_range(32768)) - 16384);
    end
    return t;
  endfunction

  function automatic qoa_in_t mk(logic [2:0] op, logic signed [15:0] ang,
                                 logic signed [15:0] ax, logic signed [15:0] ay,
                                 logic signed [15:0] az);
    qoa_in_t t;
    t.op = op; t.angle = ang; t.axis_x = ax; t.axis_y = ay; t.axis_z = az;
    return t;
  endfunction

  task automatic wait_drained();
    while (orient_sb.pending_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    qoa_in_t directed [$];
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme angles on each axis, identity with junk fields,
    // axis rotations with a zero axis, saturating axes and the unused codes.
    directed = '{
      mk(OP_ROT_X, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF),
      mk(OP_ROT_Y, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000),
      mk(OP_ROT_Z, 16'sh0000, 16'sh1234, 16'sh0000, 16'shFFFF),
      mk(OP_ROT_Z, 16'sh4000, 16'sh0000, 16'sh0000, 16'sh0000),
      mk(OP_ROT_X, -16'sh0001, 16'sh0000, 16'sh0000, 16'sh0000),
      mk(OP_IDENT, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF),
      mk(OP_ROT_AXIS, 16'sh2000, 16'sh0000, 16'sh0000, 16'sh0000),
      mk(OP_ROT_AXIS, 16'sh8000, 16'sh0000, 16'sh0000, 16'sh0000),
      mk(OP_ROT_AXIS, 16'sh4000, 16'sh4000, 16'sh0000, 16'sh0000),
      mk(OP_ROT_AXIS, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF),
      mk(OP_ROT_AXIS, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000),
      mk(OP_ROT_AXIS, 16'sh0000, 16'sh0001, -16'sh0001, 16'sh0000),
      mk(3'd5, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA),
      mk(3'd6, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000),
      mk(3'd7, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF),
      mk(OP_ROT_Y, 16'sh2AAA, 16'sh0000, 16'sh0000, 16'sh0000),
      mk(OP_IDENT, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000)
    };
    foreach (directed[i]) send_item(directed[i]);

    for (int n = 0; n < NumRandom; n++) begin
      // A calm stretch with no idling on either side.
      if (n == 300) idle_pct = 0;
      if (n == 420) idle_pct = 37;
      // The receiver holds off long enough for the block to stall its input.
      if (n == 500) hold_cycles = 600;
      // The sender pauses until everything expected has come back.
      if (n == 700) begin
        stop_sending();
        wait_drained();
      end
      send_item(rand_item());
    end

    stop_sending();
    wait_drained();
    repeat (200) @(posedge clk);
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    $display("Run covered %0d checked orientations over all operation codes,",
             orient_sb.n_checked);
    $display("with random idling, a long output hold-off and a drained pause.");
    if (error_count == 0 && orient_sb.pending_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Generous fixed limit: about a thousand full-length transactions, plus
  // stalls, taken several times over.
  initial begin
    #20ms;
    $display("Timeout with %0d results outstanding", orient_sb.pending_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire
